// File: src/p2sca_pkg.sv
package p2sca_pkg;

    // Configuration of the heap
    localparam int NUM_CLASSES = 9;
    localparam int PAGE_BYTES  = 4096;
    localparam int MIN_BLOCK   = 16;
    localparam int POOL_PAGES  = 64;
    localparam int HDR_BYTES   = 4;

    // Field widths
    localparam int REQ_W    = 12;
    localparam int OFF_W    = 18;
    localparam int STATUS_W = 2;
    localparam int TOT_W    = 19;
    localparam int NEED_W   = REQ_W + 1;

    // Derived geometry
    localparam int NUM_SLOTS      = POOL_PAGES * (PAGE_BYTES / MIN_BLOCK);
    localparam int SLOT_W         = $clog2(NUM_SLOTS);
    localparam int BLK_SH         = $clog2(MIN_BLOCK);
    localparam int SLOTS_PER_PAGE = PAGE_BYTES / MIN_BLOCK;
    localparam int PG_SH          = $clog2(SLOTS_PER_PAGE);
    localparam int PAGES_W        = $clog2(POOL_PAGES + 1);
    localparam int CLASS_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TAG_W          = REQ_W;
    localparam int TOP_BLOCK      = MIN_BLOCK << (NUM_CLASSES - 1);
    localparam int SIZE_LIMIT     = (TOP_BLOCK < PAGE_BYTES) ? TOP_BLOCK : PAGE_BYTES;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_POP,
        ST_TAG
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] free_offset;
    } t_cmd;

    typedef struct packed {
        logic [OFF_W-1:0] block_offset;
        t_status          status;
        logic [TOT_W-1:0] bytes_in_use;
        logic [TOT_W-1:0] bytes_reserved;
    } t_result;

    // Free-list pointer: a list head or a link, with an end-of-list marker
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_link;

    typedef struct packed {
        logic               ok;
        logic [CLASS_W-1:0] idx;
    } t_class_sel;

    // Smallest class whose block holds need bytes
    function automatic t_class_sel class_of(input logic [NEED_W-1:0] need);
        t_class_sel sel;
        sel.ok  = 1'b0;
        sel.idx = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if ((MIN_BLOCK << i) >= int'(need)) begin
                sel.ok  = 1'b1;
                sel.idx = CLASS_W'(i);
            end
        end
        return sel;
    endfunction

endpackage

// File: src/power_of_two_size_class_allocator.sv
// Segregated power-of-two allocator over a heap of 64 pages of 4096 bytes. An
// allocate picks the smallest of nine classes (16..4096-byte blocks) that holds
// request_bytes plus a 4-byte header, pops that class's LIFO free list, or else
// carves the next block (highest address first) from the page the class is
// cutting, taking a fresh page from the heap when needed; it returns the payload
// offset block+4. A free pushes the block back onto the class named by its size
// tag; malformed offsets are dropped silently. Each command yields exactly one
// result, shown on o_result for one cycle with o_done high; the receiver cannot
// stall, so capture it on that cycle. The result is registered out of the lookup
// step for rejected commands and for carving, and out of a following pop or tag
// step for a pop from a free list or a well-formed free, where the registered
// read of the link or size-tag memory sits between the head lookup and the write-back.
// busy is high from the transfer until the result cycle, so one command is in
// flight at a time; a new start can be taken in the same cycle its predecessor's
// result is shown. No clearing pass is needed after reset.
module power_of_two_size_class_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  p2sca_pkg::t_cmd   i_cmd,
    output logic              o_done,
    output p2sca_pkg::t_result o_result
);

    // Control state
    p2sca_pkg::t_state r_state, n_state;
    p2sca_pkg::t_link  r_head [p2sca_pkg::NUM_CLASSES];
    p2sca_pkg::t_link  n_head [p2sca_pkg::NUM_CLASSES];
    logic              r_cur_live [p2sca_pkg::NUM_CLASSES];
    logic              n_cur_live [p2sca_pkg::NUM_CLASSES];
    logic [p2sca_pkg::PAGES_W-1:0] r_pages, n_pages;
    logic [p2sca_pkg::TOT_W-1:0]   r_in_use, n_in_use;
    logic [p2sca_pkg::TOT_W-1:0]   r_reserved, n_reserved;
    logic              r_done, n_done;

    // Payload state
    p2sca_pkg::t_cmd   r_cmd;
    logic [p2sca_pkg::SLOT_W-1:0] r_cur_slot [p2sca_pkg::NUM_CLASSES];
    logic [p2sca_pkg::SLOT_W-1:0] n_cur_slot [p2sca_pkg::NUM_CLASSES];
    p2sca_pkg::t_result r_result, n_result;

    // Memory ports
    logic                          link_we;
    logic [p2sca_pkg::SLOT_W-1:0]  link_waddr;
    p2sca_pkg::t_link              link_wdata;
    logic [p2sca_pkg::SLOT_W-1:0]  link_raddr;
    p2sca_pkg::t_link              link_rdata;
    logic                          tag_we;
    logic [p2sca_pkg::SLOT_W-1:0]  tag_waddr;
    logic [p2sca_pkg::TAG_W-1:0]   tag_wdata;
    logic [p2sca_pkg::SLOT_W-1:0]  tag_raddr;
    logic [p2sca_pkg::TAG_W-1:0]   tag_rdata;

    // Allocate decode
    logic [p2sca_pkg::NEED_W-1:0]  a_need;
    logic                          a_too_large;
    p2sca_pkg::t_class_sel         a_sel;
    logic [p2sca_pkg::CLASS_W-1:0] a_cls;
    logic [p2sca_pkg::SLOT_W-1:0]  a_blk;
    p2sca_pkg::t_link              a_head;
    logic [p2sca_pkg::SLOT_W-1:0]  a_page_base;
    logic [p2sca_pkg::SLOT_W-1:0]  a_page_top;
    logic [p2sca_pkg::SLOT_W-1:0]  a_take;
    logic                          a_take_last;
    logic                          a_can_carve;

    // Free decode
    logic [p2sca_pkg::OFF_W-1:0]   f_blk;
    logic [p2sca_pkg::TOT_W-1:0]   f_limit;
    logic                          f_ok;
    logic [p2sca_pkg::SLOT_W-1:0]  f_slot;
    logic [p2sca_pkg::NEED_W-1:0]  t_need;
    p2sca_pkg::t_class_sel         t_sel;

    // Result assembly
    logic [p2sca_pkg::SLOT_W-1:0]  res_slot;
    logic                          res_got;
    p2sca_pkg::t_status            res_status;

    p2sca_ram #(
        .WIDTH ($bits(p2sca_pkg::t_link)),
        .DEPTH (p2sca_pkg::NUM_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    p2sca_ram #(
        .WIDTH (p2sca_pkg::TAG_W),
        .DEPTH (p2sca_pkg::NUM_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    assign busy     = (r_state != p2sca_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Decode the held allocate: class, block size in slots, and carve position
    always_comb begin
        a_need      = p2sca_pkg::NEED_W'(r_cmd.request_bytes)
                    + p2sca_pkg::NEED_W'(p2sca_pkg::HDR_BYTES);
        a_too_large = (int'(a_need) > p2sca_pkg::SIZE_LIMIT);
        a_sel       = p2sca_pkg::class_of(a_need);
        a_cls       = a_sel.idx;
        a_blk       = p2sca_pkg::SLOT_W'(1) << a_cls;
        a_head      = r_head[a_cls];
        a_page_base = p2sca_pkg::SLOT_W'(r_pages) << p2sca_pkg::PG_SH;
        a_page_top  = a_page_base + p2sca_pkg::SLOT_W'(p2sca_pkg::SLOTS_PER_PAGE) - a_blk;
        a_take      = r_cur_live[a_cls] ? r_cur_slot[a_cls] : a_page_top;
        a_take_last = (a_take[p2sca_pkg::PG_SH-1:0] == '0);
        a_can_carve = r_cur_live[a_cls]
                   || (r_pages < p2sca_pkg::PAGES_W'(p2sca_pkg::POOL_PAGES));
    end

    // Decode the held free: block address must be aligned and inside taken pages
    always_comb begin
        f_blk   = r_cmd.free_offset - p2sca_pkg::OFF_W'(p2sca_pkg::HDR_BYTES);
        f_limit = p2sca_pkg::TOT_W'(r_pages) << (p2sca_pkg::PG_SH + p2sca_pkg::BLK_SH);
        f_ok    = (r_cmd.free_offset >= p2sca_pkg::OFF_W'(p2sca_pkg::HDR_BYTES))
               && (f_blk[p2sca_pkg::BLK_SH-1:0] == '0)
               && (p2sca_pkg::TOT_W'(f_blk) < f_limit);
        f_slot  = p2sca_pkg::SLOT_W'(f_blk >> p2sca_pkg::BLK_SH);
        t_need  = p2sca_pkg::NEED_W'(tag_rdata) + p2sca_pkg::NEED_W'(p2sca_pkg::HDR_BYTES);
        t_sel   = p2sca_pkg::class_of(t_need);
    end

    // Reads follow the held command; the registered data is used in the next cycle
    assign link_raddr = a_head.slot;
    assign tag_raddr  = f_slot;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            p2sca_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = p2sca_pkg::ST_LOOKUP;
                end
            end
            p2sca_pkg::ST_LOOKUP: begin
                if (r_cmd.op == p2sca_pkg::OP_ALLOC) begin
                    n_state = (!a_too_large && a_head.valid) ? p2sca_pkg::ST_POP
                                                             : p2sca_pkg::ST_IDLE;
                end else begin
                    n_state = f_ok ? p2sca_pkg::ST_TAG : p2sca_pkg::ST_IDLE;
                end
            end
            p2sca_pkg::ST_POP: n_state = p2sca_pkg::ST_IDLE;
            p2sca_pkg::ST_TAG: n_state = p2sca_pkg::ST_IDLE;
            default:           n_state = p2sca_pkg::ST_IDLE;
        endcase
    end

    // Read-modify-write of lists, cursors and totals; assemble the result
    always_comb begin
        n_head     = r_head;
        n_cur_live = r_cur_live;
        n_cur_slot = r_cur_slot;
        n_pages    = r_pages;
        n_in_use   = r_in_use;
        n_reserved = r_reserved;
        n_done     = 1'b0;
        n_result   = r_result;
        link_we    = 1'b0;
        link_waddr = f_slot;
        link_wdata = r_head[t_sel.idx];
        tag_we     = 1'b0;
        tag_waddr  = a_take;
        tag_wdata  = r_cmd.request_bytes;
        res_slot   = a_take;
        res_got    = 1'b0;
        res_status = p2sca_pkg::STAT_OK;

        unique case (r_state)
            p2sca_pkg::ST_LOOKUP: begin
                if (r_cmd.op == p2sca_pkg::OP_ALLOC) begin
                    if (a_too_large) begin
                        n_done     = 1'b1;
                        res_status = p2sca_pkg::STAT_TOO_LARGE;
                    end else if (a_head.valid) begin
                        // wait for the link read
                    end else if (a_can_carve) begin
                        if (!r_cur_live[a_cls]) begin
                            n_pages    = r_pages + p2sca_pkg::PAGES_W'(1);
                            n_reserved = r_reserved
                                       + p2sca_pkg::TOT_W'(p2sca_pkg::PAGE_BYTES);
                        end
                        // advance the cursor, or retire it at the page's lowest block
                        n_cur_live[a_cls] = !a_take_last;
                        n_cur_slot[a_cls] = a_take_last ? a_take : a_take - a_blk;
                        tag_we     = 1'b1;
                        n_in_use   = r_in_use + p2sca_pkg::TOT_W'(r_cmd.request_bytes);
                        n_done     = 1'b1;
                        res_got    = 1'b1;
                    end else begin
                        n_done     = 1'b1;
                        res_status = p2sca_pkg::STAT_EXHAUSTED;
                    end
                end else if (!f_ok) begin
                    // drop a malformed free
                    n_done = 1'b1;
                end
            end
            p2sca_pkg::ST_POP: begin
                n_head[a_cls] = link_rdata;
                tag_we        = 1'b1;
                tag_waddr     = a_head.slot;
                n_in_use      = r_in_use + p2sca_pkg::TOT_W'(r_cmd.request_bytes);
                res_slot      = a_head.slot;
                res_got       = 1'b1;
                n_done        = 1'b1;
            end
            p2sca_pkg::ST_TAG: begin
                if (t_sel.ok) begin
                    link_we             = 1'b1;
                    n_head[t_sel.idx]   = '{valid: 1'b1, slot: f_slot};
                    n_in_use = (r_in_use >= p2sca_pkg::TOT_W'(tag_rdata))
                             ? r_in_use - p2sca_pkg::TOT_W'(tag_rdata)
                             : '0;
                end
                n_done = 1'b1;
            end
            p2sca_pkg::ST_IDLE: begin
                // hold
            end
            default: begin
                // hold
            end
        endcase

        if (n_done) begin
            n_result.block_offset   = res_got
                ? p2sca_pkg::OFF_W'({res_slot, {p2sca_pkg::BLK_SH{1'b0}}})
                  + p2sca_pkg::OFF_W'(p2sca_pkg::HDR_BYTES)
                : '0;
            n_result.status         = res_status;
            n_result.bytes_in_use   = n_in_use;
            n_result.bytes_reserved = n_reserved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= p2sca_pkg::ST_IDLE;
            r_pages    <= '0;
            r_in_use   <= '0;
            r_reserved <= '0;
            r_done     <= 1'b0;
            for (int i = 0; i < p2sca_pkg::NUM_CLASSES; i++) begin
                r_head[i]     <= '{valid: 1'b0, slot: '0};
                r_cur_live[i] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_cur_live <= n_cur_live;
            r_pages    <= n_pages;
            r_in_use   <= n_in_use;
            r_reserved <= n_reserved;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_cur_slot <= n_cur_slot;
        r_result   <= n_result;
    end

    // A result only follows work on a command
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != p2sca_pkg::ST_IDLE))
        else $error("result strobe without a command in flight");

    // A start transfer always enters the lookup step
    a_start_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == p2sca_pkg::ST_LOOKUP))
        else $error("start transfer did not enter lookup");

    // Reserved bytes track the page count
    a_reserved_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reserved == (p2sca_pkg::TOT_W'(r_pages)
                       << (p2sca_pkg::PG_SH + p2sca_pkg::BLK_SH)))
        else $error("reserved total out of step with page count");

    // Never take more pages than the heap has
    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= p2sca_pkg::PAGES_W'(p2sca_pkg::POOL_PAGES))
        else $error("page count beyond heap");

    // A failed allocate reports a zero offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != p2sca_pkg::STAT_OK))
            |-> (o_result.block_offset == '0))
        else $error("failed result carries an offset");

endmodule

// File: src/p2sca_ram.sv
module p2sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import p2sca_pkg::*;

    // Runs of well over a thousand commands fit well inside this limit even with
    // the longest gaps; it allows far more before giving up.
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    // -------------------------------------------------------------------------
    // DUT hookup
    // -------------------------------------------------------------------------
    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_done;
    t_result o_result;

    power_of_two_size_class_allocator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // Shadow copy of the heap bookkeeping. A free-list head or link of -1 means
    // the end of the list.
    // -------------------------------------------------------------------------
    int fl_head    [NUM_CLASSES];
    int carve_ptr  [NUM_CLASSES];
    bit carve_live [NUM_CLASSES];
    int fl_link    [NUM_SLOTS];
    int blk_tag    [NUM_SLOTS];
    int pages_taken;
    int in_use_sum;
    int reserved_sum;

    // Smallest class whose block holds need bytes; NUM_CLASSES when none does.
    function automatic int size_class(int need);
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if ((MIN_BLOCK << k) >= need) return k;
        end
        return NUM_CLASSES;
    endfunction

    // Hand out the next block of the page a class is cutting, top down.
    function automatic int carve_next(int cls, int blk);
        int addr;
        addr = carve_ptr[cls];
        if (addr % PAGE_BYTES == 0) begin
            carve_live[cls] = 1'b0;
        end else begin
            carve_ptr[cls] = addr - blk;
        end
        return addr;
    endfunction

    // Apply one command to the shadow heap and return the reply it must give.
    function automatic t_result predict_heap_reply(t_cmd c);
        t_result r;
        int      need;
        int      cls;
        int      blk;
        int      addr;
        int      slot;
        int      b;
        int      tag;
        int      base;
        bit      got;
        r        = '0;
        r.status = STAT_OK;
        if (c.op == OP_ALLOC) begin
            need = int'(c.request_bytes) + HDR_BYTES;
            if (need > SIZE_LIMIT) begin
                r.status = STAT_TOO_LARGE;
            end else begin
                cls  = size_class(need);
                blk  = MIN_BLOCK << cls;
                got  = 1'b1;
                addr = 0;
                if (fl_head[cls] >= 0) begin
                    // pop the LIFO free list
                    slot         = fl_head[cls];
                    fl_head[cls] = fl_link[slot];
                    addr         = slot * MIN_BLOCK;
                end else if (carve_live[cls]) begin
                    addr = carve_next(cls, blk);
                end else if (pages_taken < POOL_PAGES) begin
                    // open a fresh page and cut it from its top block down
                    base            = pages_taken * PAGE_BYTES;
                    pages_taken    += 1;
                    reserved_sum   += PAGE_BYTES;
                    carve_ptr[cls]  = base + (PAGE_BYTES / blk - 1) * blk;
                    carve_live[cls] = 1'b1;
                    addr            = carve_next(cls, blk);
                end else begin
                    got      = 1'b0;
                    r.status = STAT_EXHAUSTED;
                end
                if (got) begin
                    blk_tag[addr / MIN_BLOCK]   = int'(c.request_bytes);
                    in_use_sum                 += int'(c.request_bytes);
                    r.block_offset              = OFF_W'(addr + HDR_BYTES);
                end
            end
        end else if (int'(c.free_offset) >= HDR_BYTES) begin
            b = int'(c.free_offset) - HDR_BYTES;
            if (b % MIN_BLOCK == 0 && b < pages_taken * PAGE_BYTES) begin
                slot = b / MIN_BLOCK;
                tag  = blk_tag[slot];
                cls  = size_class(tag + HDR_BYTES);
                if (cls < NUM_CLASSES) begin
                    fl_link[slot] = fl_head[cls];
                    fl_head[cls]  = slot;
                    // saturate rather than wrap on a repeated free
                    in_use_sum    = (in_use_sum >= tag) ? in_use_sum - tag : 0;
                end
            end
        end
        r.bytes_in_use   = TOT_W'(in_use_sum);
        r.bytes_reserved = TOT_W'(reserved_sum);
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Bookkeeping shared by the driver and the monitor
    // -------------------------------------------------------------------------
    t_result          heap_replies_due[$];
    logic [OFF_W-1:0] live_offs[$];
    bit               typed_pending;
    t_result          typed_result;
    int               n_accepted;
    int               n_errors;
    int               n_alloc_ok;
    int               n_frees;
    int               n_exhausted;
    int               n_too_large;
    int               cycle_count;
    int               gap_max;
    t_result          mon_want;
    t_result          mon_pred;

    // -------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check the reply first, since a new
    // transfer can land in the same cycle as the previous command's reply.
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_done) begin
                if (heap_replies_due.size() == 0) begin
                    $display("%0t: unexpected reply: expected none, %s%0d %0d %0d %0d",
                             $time, "got off/st/use/rsv = ",
                             o_result.block_offset, o_result.status,
                             o_result.bytes_in_use, o_result.bytes_reserved);
                    n_errors++;
                end else begin
                    mon_want = heap_replies_due.pop_front();
                    if (o_result.block_offset !== mon_want.block_offset) begin
                        $display("%0t: block_offset: expected %0d, got %0d",
                                 $time, mon_want.block_offset, o_result.block_offset);
                        n_errors++;
                    end
                    if (o_result.status !== mon_want.status) begin
                        $display("%0t: status: expected %0d, got %0d",
                                 $time, mon_want.status, o_result.status);
                        n_errors++;
                    end
                    if (o_result.bytes_in_use !== mon_want.bytes_in_use) begin
                        $display("%0t: bytes_in_use: expected %0d, got %0d",
                                 $time, mon_want.bytes_in_use, o_result.bytes_in_use);
                        n_errors++;
                    end
                    if (o_result.bytes_reserved !== mon_want.bytes_reserved) begin
                        $display("%0t: bytes_reserved: expected %0d, got %0d",
                                 $time, mon_want.bytes_reserved, o_result.bytes_reserved);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                // a transfer: advance the shadow heap and queue the reply it owes
                mon_pred = predict_heap_reply(i_cmd);
                if (i_cmd.op == OP_FREE) begin
                    n_frees++;
                end else if (mon_pred.status == STAT_OK) begin
                    n_alloc_ok++;
                    live_offs.push_back(mon_pred.block_offset);
                end else if (mon_pred.status == STAT_EXHAUSTED) begin
                    n_exhausted++;
                end else begin
                    n_too_large++;
                end
                heap_replies_due.push_back(typed_pending ? typed_result : mon_pred);
                n_accepted++;
            end
        end
    end

    // Watchdog: a stuck handshake or a missing reply ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timed out with %0d replies outstanding", $time,
                 heap_replies_due.size());
        $display("Mismatches found");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Driver: change inputs at the falling edge only. Every task below that waits
    // on the clock starts and ends on a falling edge.
    // -------------------------------------------------------------------------
    task automatic send_cmd(input t_cmd cmd, input bit typed, input t_result want);
        int gap;
        int target;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // hold start high straight into the next command when there is no gap
        start        <= 1'b1;
        i_cmd        <= cmd;
        typed_pending = typed;
        typed_result  = want;
        target        = n_accepted + 1;
        while (n_accepted < target) @(negedge i_clk);
    endtask

    // Hold off until every owed reply has come back.
    task automatic drain_replies();
        start <= 1'b0;
        do @(negedge i_clk); while (heap_replies_due.size() != 0);
    endtask

    task automatic send_random_item();
        t_cmd             cmd;
        int               pick;
        int               idx;
        logic [OFF_W-1:0] off;
        cmd.op            = OP_ALLOC;
        cmd.request_bytes = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
        cmd.free_offset   = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
        pick              = $urandom_range(0, 99);
        if (pick < 50 || (live_offs.size() == 0 && pick < 90)) begin
            // allocate, mostly small, with the odd oversize request
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cmd.request_bytes = REQ_W'($urandom_range(0, 60));
            end else if (pick < 75) begin
                cmd.request_bytes = REQ_W'($urandom_range(0, 1020));
            end else if (pick < 85) begin
                cmd.request_bytes = REQ_W'($urandom_range(1021, 2044));
            end else if (pick < 93) begin
                cmd.request_bytes = REQ_W'($urandom_range(2045, SIZE_LIMIT - HDR_BYTES));
            end else if (pick < 96) begin
                cmd.request_bytes = REQ_W'($urandom_range(SIZE_LIMIT - HDR_BYTES + 1, 4095));
            end
        end else if (pick < 90) begin
            // free a block that is currently handed out
            cmd.op          = OP_FREE;
            idx             = $urandom_range(0, live_offs.size() - 1);
            cmd.free_offset = live_offs[idx];
            live_offs.delete(idx);
        end else begin
            // malformed free; knock an offset that would land on a block off
            // alignment, so no block is pushed that was never handed out
            cmd.op = OP_FREE;
            off    = cmd.free_offset;
            if (int'(off) >= HDR_BYTES && (int'(off) - HDR_BYTES) % MIN_BLOCK == 0 &&
                int'(off) - HDR_BYTES < pages_taken * PAGE_BYTES) begin
                off[0] = 1'b1;
            end
            cmd.free_offset = off;
        end
        send_cmd(cmd, 1'b0, '0);
    endtask

    // -------------------------------------------------------------------------
    // Directed table
    // -------------------------------------------------------------------------
    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result want;
    } t_stim_row;

    t_stim_row stim_rows[$];

    task automatic add_row(input t_op op, input int req, input int off, input bit typed,
                           input int e_off, input t_status e_st, input int e_use,
                           input int e_rsv);
        t_stim_row row;
        row.cmd.op                 = op;
        row.cmd.request_bytes      = REQ_W'(req);
        row.cmd.free_offset        = OFF_W'(off);
        row.typed                  = typed;
        row.want.block_offset      = OFF_W'(e_off);
        row.want.status            = e_st;
        row.want.bytes_in_use      = TOT_W'(e_use);
        row.want.bytes_reserved    = TOT_W'(e_rsv);
        stim_rows.push_back(row);
    endtask

    // -------------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------------
    initial begin
        t_cmd cmd;
        int   burst_guard;
        int   exhausted_goal;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = '0;
        typed_pending = 1'b0;
        typed_result  = '0;
        n_accepted    = 0;
        n_errors      = 0;
        n_alloc_ok    = 0;
        n_frees       = 0;
        n_exhausted   = 0;
        n_too_large   = 0;
        cycle_count   = 0;
        gap_max       = 10;
        pages_taken   = 0;
        in_use_sum    = 0;
        reserved_sum  = 0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            fl_head[k]    = -1;
            carve_ptr[k]  = 0;
            carve_live[k] = 1'b0;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            fl_link[s] = -1;
            blk_tag[s] = 0;
        end

        // Empty heap answers, oversize requests, the first carve of a page
        add_row(OP_FREE,     0,       0, 1'b1,    0, STAT_OK,        0,    0);
        add_row(OP_ALLOC, 4093,       0, 1'b1,    0, STAT_TOO_LARGE, 0,    0);
        add_row(OP_ALLOC, 4095, 'h3FFFF, 1'b1,    0, STAT_TOO_LARGE, 0,    0);
        add_row(OP_ALLOC,    0, 'h3FFFF, 1'b1, 4084, STAT_OK,        0, 4096);
        add_row(OP_ALLOC,  500,       0, 1'b1, 7684, STAT_OK,      500, 8192);
        // Repeated free of the 512-byte block drives the total below its tag
        add_row(OP_ALLOC,   12,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_FREE, 'hFFF,    7684, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_FREE,     0,    7684, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC,  300,       0, 1'b0, 0, STAT_OK, 0, 0);
        // Largest request and class boundaries across every class but the 16- and 512-byte ones
        add_row(OP_ALLOC, 4092,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC, 2044,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC, 2045,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC,   13,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC,   60,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC,  124,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC,  252,       0, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC, 1020,       0, 1'b0, 0, STAT_OK, 0, 0);
        // Malformed frees: below the header, misaligned, past the taken pages
        add_row(OP_FREE, 'hFFF,       3, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_FREE,     0,       5, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_FREE,     0, 'h3FFF4, 1'b0, 0, STAT_OK, 0, 0);
        // Free then reuse from the smallest class's list
        add_row(OP_FREE, 'h555,    4068, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC,    7, 'h2AAAA, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC, 'hAAA, 'h2AAAA, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_ALLOC, 'h555, 'h15555, 1'b0, 0, STAT_OK, 0, 0);
        add_row(OP_FREE, 'hAAA, 'h15554, 1'b0, 0, STAT_OK, 0, 0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i]) begin
            // drop a freed offset from the live pool so random frees skip it
            if (stim_rows[i].cmd.op == OP_FREE) begin
                for (int k = 0; k < live_offs.size(); k++) begin
                    if (live_offs[k] == stim_rows[i].cmd.free_offset) begin
                        live_offs.delete(k);
                        break;
                    end
                end
            end
            send_cmd(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].want);
        end
        drain_replies();

        // Random traffic; alternate long gaps, back-to-back, and short gaps
        for (int chunk = 0; chunk < 9; chunk++) begin
            gap_max = (chunk % 3 == 0) ? 10 : ((chunk % 3 == 1) ? 0 : 3);
            repeat (100) send_random_item();
            if (chunk == 4) drain_replies();
        end
        drain_replies();

        // Run the heap out of pages with top-class requests
        gap_max        = 2;
        exhausted_goal = n_exhausted + 3;
        burst_guard    = 0;
        while (n_exhausted < exhausted_goal && burst_guard < 300) begin
            cmd.op            = OP_ALLOC;
            cmd.request_bytes = REQ_W'($urandom_range(2045, SIZE_LIMIT - HDR_BYTES));
            cmd.free_offset   = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
            send_cmd(cmd, 1'b0, '0);
            burst_guard++;
        end

        // Keep going on the full heap: only recycling and pages already being cut can satisfy requests now
        for (int chunk = 0; chunk < 4; chunk++) begin
            gap_max = (chunk % 2 == 0) ? 10 : 0;
            repeat (100) send_random_item();
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d commands: %0d allocations granted, %0d frees, %s",
                 n_accepted, n_alloc_ok, n_frees, "plus refusals below");
        $display("%0d out of pages, %0d oversize; heap ended with %0d of %0d pages taken",
                 n_exhausted, n_too_large, pages_taken, POOL_PAGES);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
src/p2sca_pkg.sv
src/p2sca_ram.sv
src/power_of_two_size_class_allocator.sv
tb/tb.sv
